>>> hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared constants and types of the sorted tolerance set
// Table capacity, field widths, the result record and the sequencer states.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int TOL_W    = 31;
	localparam int RES_W    = 9;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef struct packed {
		logic             hit;
		logic [RES_W-1:0] index;
		logic             inserted;
		logic             full_res;
		logic [RES_W-1:0] count;
	} sts_res_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PROBE  = 7'b0000010,
		ST_DIFF   = 7'b0000100,
		ST_DECIDE = 7'b0001000,
		ST_SHIFT  = 7'b0010000,
		ST_STORE  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} sts_state_t;

endpackage

>>> hdl/sorted_tolerance_set.sv
// ----------------------------------------------------------------------------
// sorted_tolerance_set: ascending table of Q16.16 values with tolerant search
// Top level: stream channels, tolerance register and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: s_tuser = action (0 insert if absent, 1 lookup), s_tdata =
//   signed Q16.16 value. One output beat per input beat, in order.
//   Output beat: m_tuser = {full_res, inserted, hit}, m_tdata = {count, index}.
//   The tolerance is written through cfg_we / cfg_wdata; the user must write
//   it only while the block idles, as the block itself does not enforce this.
//   Each search probe makes one table RAM read (at most log2(CAPACITY)+1
//   probes). An insert that stores then moves the entries from index up to
//   count-1 up one slot per cycle through the RAM's read port and write
//   port, and writes the new value at index.
//   One item is in work at a time; the next input beat is taken as soon as
//   the previous result sits in the output register.
//   Reset clears the entry count and the tolerance; table contents are not
//   cleared, as only entries below the count are ever read.
//   While the receiver stalls, the output register holds its beat and the
//   engine holds a finished result until the register frees.
// ----------------------------------------------------------------------------
module sorted_tolerance_set import sts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,   // tolerance
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,     // [31:0] value
	input  logic             s_tuser,     // [0] action
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,     // [8:0] index, [17:9] count, zero fill
	output logic [2:0]       m_tuser      // [0] hit, [1] inserted, [2] full_res
);

	logic [TOL_W-1:0] tol_q;
	logic             res_valid;
	logic             res_ready;
	sts_res_t         res;
	sts_res_t         out_q;
	logic             out_valid_q;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	sts_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.tolerance  (tol_q),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item_action(s_tuser),
		.item_value (s_tdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register: load when empty or draining
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.count, out_q.index};
	assign m_tuser  = {out_q.full_res, out_q.inserted, out_q.hit};

endmodule

>>> hdl/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/sts_engine.sv
// ----------------------------------------------------------------------------
// sts_engine: search and insert sequencer
// Runs the tolerant binary search over the table RAM, then shifts the upper
// entries up one slot at a time and stores a new value on an insert miss that finds room.
// ----------------------------------------------------------------------------
module sts_engine import sts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [TOL_W-1:0] tolerance,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic             item_action,
	input  logic [VAL_W-1:0] item_value,
	output logic             res_valid,
	input  logic             res_ready,
	output sts_res_t         res
);

	sts_state_t         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hix_q;
	logic [ADDR_W-1:0]  mid_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   sh_q;
	logic [ADDR_W-1:0]  wa_s1;
	logic               pend_s1;
	logic               act_q;
	logic [VAL_W-1:0]   key_q;
	logic signed [VAL_W:0] diff_s1;
	sts_res_t           res_q;

	logic [CNT_W-1:0]   span;
	logic [CNT_W-1:0]   mid_full;
	logic [CNT_W-1:0]   sh_dec;
	logic signed [VAL_W:0] tol_s;
	logic               in_tol;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [VAL_W-1:0]   ram_rdata;

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_DONE);
	assign res        = res_q;

	// probe point and tolerance window
	assign span     = hix_q - lo_q - CNT_W'(1);
	assign mid_full = lo_q + (span >> 1);
	assign sh_dec   = sh_q - CNT_W'(1);
	assign tol_s    = $signed({2'b00, tolerance});
	assign in_tol   = (diff_s1 <= tol_s) && (diff_s1 >= -tol_s);

	// RAM port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_s1;
		ram_wdata = ram_rdata;
		ram_raddr = mid_full[ADDR_W-1:0];
		if (state_q == ST_SHIFT) begin
			ram_we    = pend_s1;
			ram_raddr = sh_dec[ADDR_W-1:0];
		end else if (state_q == ST_STORE) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q[ADDR_W-1:0];
			ram_wdata = key_q;
		end
	end

	sts_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				act_q <= item_action;
				key_q <= item_value;
				lo_q  <= '0;
				hix_q <= count_q;
			end
			ST_PROBE: begin
				mid_q <= mid_full[ADDR_W-1:0];
				pos_q <= lo_q;
				sh_q  <= count_q;
			end
			ST_DIFF: begin
				diff_s1 <= $signed({ram_rdata[VAL_W-1], ram_rdata})
					- $signed({key_q[VAL_W-1], key_q});
			end
			ST_DECIDE: begin
				pos_q <= CNT_W'(mid_q);
				if (!in_tol) begin
					if (diff_s1 > 0) begin
						hix_q <= CNT_W'(mid_q);
					end else begin
						lo_q <= CNT_W'(mid_q) + CNT_W'(1);
					end
				end
			end
			ST_SHIFT: begin
				wa_s1 <= sh_q[ADDR_W-1:0];
				if (sh_q > pos_q) begin
					sh_q <= sh_dec;
				end
			end
			ST_STORE, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					pend_s1 <= 1'b0;
					if (lo_q < hix_q) begin
						state_q <= ST_DIFF;
					end else begin
						// miss: low is the insertion point
						res_q.hit      <= 1'b0;
						res_q.index    <= RES_W'(lo_q);
						res_q.inserted <= 1'b0;
						res_q.full_res <= 1'b0;
						res_q.count    <= RES_W'(count_q);
						if (act_q == ACT_INSERT) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								res_q.full_res <= 1'b1;
								state_q        <= ST_DONE;
							end else begin
								state_q <= ST_SHIFT;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIFF: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (in_tol) begin
						res_q.hit      <= 1'b1;
						res_q.index    <= RES_W'(mid_q);
						res_q.inserted <= 1'b0;
						res_q.full_res <= 1'b0;
						res_q.count    <= RES_W'(count_q);
						state_q        <= ST_DONE;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_SHIFT: begin
					// move entry sh-1 to sh, write lands in the cycle after the read
					if (sh_q > pos_q) begin
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					count_q        <= count_q + CNT_W'(1);
					res_q.inserted <= 1'b1;
					res_q.count    <= RES_W'(count_q + CNT_W'(1));
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
